// ===== hw/rtl/face_velocity_interpolation_core_macros.svh =====
// Assertion helpers used by fvi_back. Each expects clk and rst in scope.
`ifndef FACE_VELOCITY_INTERPOLATION_CORE_MACROS_SVH
`define FACE_VELOCITY_INTERPOLATION_CORE_MACROS_SVH

// ante holds in a cycle -> cons holds in the same cycle
`define FVI_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// ante holds in a cycle -> cons holds in the next cycle
`define FVI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/fvi_pkg.sv =====
package fvi_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned NORM_W      = 16;
  localparam int unsigned DIST_W      = 31;
  localparam int unsigned DT_W        = 31;
  localparam int unsigned PADDR_W     = 3;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // one quotient bit per step over the 64-bit dividend
  localparam int unsigned DIV_STEPS   = 64;
  localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS);

  // register index, taken from paddr[2]
  localparam logic REG_TIME_STEP = 1'b0;

  typedef logic signed [DATA_W-1:0] q16_t;
  typedef logic signed [NORM_W-1:0] norm_t;

  typedef struct packed {
    q16_t       pressure;
    q16_t [2:0] vel;
    q16_t [2:0] grad;
  } cell_t;

  typedef struct packed {
    cell_t             left;
    cell_t             right;
    norm_t [2:0]       normal;
    logic [DIST_W-1:0] distance;
  } face_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    q16_t       normal_vel;
    q16_t [2:0] vel;
    q16_t       pressure;
  } result_t;

endpackage

// ===== hw/rtl/fvi_front.sv =====
module fvi_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  logic                        full,
  input  logic                        side,
  input  fvi_pkg::cell_t              cur_cell,
  input  fvi_pkg::norm_t [2:0]        normal,
  input  logic [fvi_pkg::DIST_W-1:0]  distance,
  output logic                        q_push,
  output fvi_pkg::face_t              q_data
);

  logic                       accept;
  logic                       left_present;
  fvi_pkg::cell_t             held_cell;
  fvi_pkg::norm_t [2:0]       held_normal;
  logic [fvi_pkg::DIST_W-1:0] held_distance;

  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_present <= 1'b0;
    end else if (accept) begin
      if (!side) begin
        left_present <= 1'b1;
      end else if (left_present) begin
        left_present <= 1'b0;
      end
    end
  end

  // a later left item replaces the held one
  always_ff @(posedge clk) begin
    if (accept && !side) begin
      held_cell     <= cur_cell;
      held_normal   <= normal;
      held_distance <= distance;
    end
  end

  // right item without a held left item is dropped
  assign q_push = accept && side && left_present;

  always_comb begin
    q_data.left     = held_cell;
    q_data.right    = cur_cell;
    q_data.normal   = held_normal;
    q_data.distance = held_distance;
  end

endmodule

// ===== hw/rtl/fvi_queue.sv =====
module fvi_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  fvi_pkg::face_t    wr_data,
  input  logic              pop,
  output fvi_pkg::face_t    rd_data,
  output fvi_pkg::q_stat_t  stat
);

  fvi_pkg::face_t                entries [fvi_pkg::QUEUE_DEPTH];
  logic [fvi_pkg::QPTR_W-1:0]    wr_ptr;
  logic [fvi_pkg::QPTR_W-1:0]    rd_ptr;
  logic [fvi_pkg::QCNT_W-1:0]    count;

  function automatic logic [fvi_pkg::QPTR_W-1:0] ptr_inc(
    input logic [fvi_pkg::QPTR_W-1:0] p
  );
    if (p == fvi_pkg::QPTR_W'(fvi_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + fvi_pkg::QPTR_W'(1);
  endfunction

  assign stat.full  = (count == fvi_pkg::QCNT_W'(fvi_pkg::QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign rd_data    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + fvi_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - fvi_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

// ===== hw/rtl/fvi_back.sv =====
`include "face_velocity_interpolation_core_macros.svh"

module fvi_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [fvi_pkg::DT_W-1:0]  time_step,
  input  fvi_pkg::face_t            head,
  input  logic                      q_empty,
  output logic                      q_pop,
  input  logic                      pop,
  output logic                      out_valid,
  output fvi_pkg::result_t          result
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MUL,
    ST_ACC,
    ST_DIVPREP,
    ST_DIV,
    ST_FINAL
  } state_t;

  typedef enum logic [3:0] {
    OP_VX,
    OP_VY,
    OP_VZ,
    OP_GX,
    OP_GY,
    OP_GZ,
    OP_PRES,
    OP_GLO,
    OP_GHI
  } op_t;

  state_t                        state;
  op_t                           op;

  logic signed [32:0]            sv [3];
  logic signed [32:0]            sg [3];
  logic signed [32:0]            dp;
  logic [32:0]                   absd;
  logic signed [31:0]            pavg;
  logic [fvi_pkg::DIST_W-1:0]    dist_r;

  logic signed [32:0]            mul_a;
  logic signed [32:0]            mul_b;
  logic signed [65:0]            prod;

  logic signed [50:0]            acc_a;
  logic signed [50:0]            acc_g;
  logic signed [82:0]            gacc;
  logic [63:0]                   mag;

  logic [63:0]                   quo;
  logic [fvi_pkg::DIST_W-1:0]    rem;
  logic [fvi_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [31:0]                   rem_sh;
  logic                          rem_ge;

  logic signed [35:0]            avg_t;
  logic signed [51:0]            g_t;
  logic signed [50:0]            avg_sum;

  logic                          q_over;
  logic [52:0]                   q_clamp;
  logic signed [53:0]            p_t;
  logic signed [55:0]            un;
  logic signed [31:0]            un_sat;
  logic                          out_free;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op)
      OP_VX: begin
        mul_a = sv[0];
        mul_b = 33'($signed(head.normal[0]));
      end
      OP_VY: begin
        mul_a = sv[1];
        mul_b = 33'($signed(head.normal[1]));
      end
      OP_VZ: begin
        mul_a = sv[2];
        mul_b = 33'($signed(head.normal[2]));
      end
      OP_GX: begin
        mul_a = sg[0];
        mul_b = 33'($signed(head.normal[0]));
      end
      OP_GY: begin
        mul_a = sg[1];
        mul_b = 33'($signed(head.normal[1]));
      end
      OP_GZ: begin
        mul_a = sg[2];
        mul_b = 33'($signed(head.normal[2]));
      end
      OP_PRES: begin
        mul_a = $signed({2'b00, time_step});
        mul_b = $signed({1'b0, absd[31:0]});
      end
      OP_GLO: begin
        mul_a = $signed({2'b00, time_step});
        mul_b = $signed({1'b0, acc_g[31:0]});
      end
      OP_GHI: begin
        mul_a = $signed({2'b00, time_step});
        mul_b = 33'($signed(acc_g[50:32]));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // restoring divider step
  assign rem_sh = {rem, quo[63]};
  assign rem_ge = (rem_sh >= {1'b0, dist_r});

  assign avg_sum = acc_a + 51'sd16384;

  // clamp the pressure quotient; anything past 2^52 saturates the sum anyway
  assign q_over  = (|quo[63:53]) || (quo[52] && (|quo[51:0]));
  assign q_clamp = q_over ? {1'b1, 52'd0} : quo[52:0];
  assign p_t     = dp[32] ? -$signed({1'b0, q_clamp}) : $signed({1'b0, q_clamp});
  assign un      = 56'(avg_t) - 56'(p_t) + 56'(g_t);

  always_comb begin
    if ((un[55:31] == '0) || (un[55:31] == '1)) begin
      un_sat = un[31:0];
    end else if (un[55]) begin
      un_sat = 32'sh8000_0000;
    end else begin
      un_sat = 32'sh7fff_ffff;
    end
  end

  assign out_free = !out_valid || pop;
  assign q_pop    = (state == ST_FINAL) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      op        <= OP_VX;
      out_valid <= 1'b0;
    end else begin
      if (pop && out_valid && (state != ST_FINAL)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            state <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          for (int i = 0; i < 3; i++) begin
            sv[i] <= 33'($signed(head.left.vel[i])) + 33'($signed(head.right.vel[i]));
            sg[i] <= 33'($signed(head.left.grad[i])) + 33'($signed(head.right.grad[i]));
          end
          dp     <= 33'($signed(head.right.pressure)) - 33'($signed(head.left.pressure));
          pavg   <= 32'((34'($signed(head.left.pressure)) +
                         34'($signed(head.right.pressure)) + 34'sd1) >>> 1);
          // zero distance counts as one LSB
          dist_r <= (head.distance == '0) ? fvi_pkg::DIST_W'(1) : head.distance;
          acc_a  <= '0;
          acc_g  <= '0;
          op     <= OP_VX;
          state  <= ST_MUL;
        end
        ST_MUL: begin
          prod  <= mul_a * mul_b;
          absd  <= dp[32] ? 33'(-dp) : 33'(dp);
          state <= ST_ACC;
        end
        ST_ACC: begin
          case (op)
            OP_VX, OP_VY, OP_VZ: begin
              acc_a <= acc_a + {{2{prod[48]}}, prod[48:0]};
            end
            OP_GX, OP_GY, OP_GZ: begin
              acc_g <= acc_g + {{2{prod[48]}}, prod[48:0]};
            end
            OP_PRES: begin
              mag <= prod[63:0] + (absd[32] ? {1'b0, time_step, 32'd0} : 64'd0);
            end
            OP_GLO: begin
              gacc <= $signed({20'd0, prod[62:0]}) + (83'sd1 <<< 30);
            end
            OP_GHI: begin
              gacc <= gacc + $signed({prod[50:0], 32'd0});
            end
            default: begin
              mag <= mag;
            end
          endcase
          if (op == OP_GHI) begin
            state <= ST_DIVPREP;
          end else begin
            op    <= op_t'(op + 4'd1);
            state <= ST_MUL;
          end
        end
        ST_DIVPREP: begin
          // round half away from zero on the magnitude
          quo     <= mag + {34'd0, dist_r[fvi_pkg::DIST_W-1:1]};
          rem     <= '0;
          div_cnt <= '0;
          avg_t   <= avg_sum[50:15];
          g_t     <= gacc[82:31];
          state   <= ST_DIV;
        end
        ST_DIV: begin
          rem     <= rem_ge ? fvi_pkg::DIST_W'(rem_sh - {1'b0, dist_r})
                            : rem_sh[fvi_pkg::DIST_W-1:0];
          quo     <= {quo[62:0], rem_ge};
          div_cnt <= div_cnt + fvi_pkg::DIV_CNT_W'(1);
          if (div_cnt == fvi_pkg::DIV_CNT_W'(fvi_pkg::DIV_STEPS - 1)) begin
            state <= ST_FINAL;
          end
        end
        ST_FINAL: begin
          // hold until the output register is free
          if (out_free) begin
            out_valid         <= 1'b1;
            result.normal_vel <= un_sat;
            for (int i = 0; i < 3; i++) begin
              result.vel[i] <= un_sat[31] ? head.right.vel[i] : head.left.vel[i];
            end
            result.pressure   <= pavg;
            state             <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `FVI_ASSERT_IMPL(a_busy_has_face, state != ST_IDLE, !q_empty, "engine busy on an empty queue")
  `FVI_ASSERT_IMPL(a_rem_below_div, state == ST_DIV, rem < dist_r, "divider remainder overran")
  `FVI_ASSERT_NEXT(a_result_once, out_valid && pop && state != ST_FINAL, !out_valid, "result still shown after it was taken")

endmodule

// ===== hw/rtl/face_velocity_interpolation_core.sv =====
// Channel   Handshake             Payload
// config    psel/penable/pwrite   paddr, pwdata, prdata (time_step at 0x0)
// input     push / full           side, cell values, normal, cell_distance
// result    empty / pop           face_normal_velocity, face_vel_xyz, face_pressure
//
// A left item is held in a register in the front; a right item that completes a face
// is queued and worked out as setup, nine products on one shared 33x33 multiplier
// (a multiply state, then an accumulate state each) and a 64-step radix-2 divide by distance.
// Reset empties the two-face queue, drops any held left item and clears time_step.
// full rises while two faces wait; a finished result waits in the output register
// while the engine carries on with the next face.
module face_velocity_interpolation_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fvi_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          push,
  output logic                          full,
  input  logic                          side,
  input  logic signed [31:0]            cell_pressure,
  input  logic signed [31:0]            vel_x,
  input  logic signed [31:0]            vel_y,
  input  logic signed [31:0]            vel_z,
  input  logic signed [31:0]            grad_x,
  input  logic signed [31:0]            grad_y,
  input  logic signed [31:0]            grad_z,
  input  logic signed [15:0]            normal_x,
  input  logic signed [15:0]            normal_y,
  input  logic signed [15:0]            normal_z,
  input  logic [30:0]                   cell_distance,
  output logic                          empty,
  input  logic                          pop,
  output logic signed [31:0]            face_normal_velocity,
  output logic signed [31:0]            face_vel_x,
  output logic signed [31:0]            face_vel_y,
  output logic signed [31:0]            face_vel_z,
  output logic signed [31:0]            face_pressure
);

  logic [fvi_pkg::DT_W-1:0]  time_step;
  fvi_pkg::cell_t            in_cell;
  fvi_pkg::norm_t [2:0]      in_normal;
  logic                      q_push;
  fvi_pkg::face_t            q_wdata;
  fvi_pkg::face_t            q_head;
  fvi_pkg::q_stat_t          q_stat;
  logic                      q_pop;
  logic                      out_valid;
  fvi_pkg::result_t          result;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= '0;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == fvi_pkg::REG_TIME_STEP)) begin
      time_step <= pwdata[fvi_pkg::DT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == fvi_pkg::REG_TIME_STEP) ? {1'b0, time_step} : 32'd0;

  always_comb begin
    in_cell.pressure = cell_pressure;
    in_cell.vel[0]   = vel_x;
    in_cell.vel[1]   = vel_y;
    in_cell.vel[2]   = vel_z;
    in_cell.grad[0]  = grad_x;
    in_cell.grad[1]  = grad_y;
    in_cell.grad[2]  = grad_z;
    in_normal[0]     = normal_x;
    in_normal[1]     = normal_y;
    in_normal[2]     = normal_z;
  end

  assign full = q_stat.full;

  fvi_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (q_stat.full),
    .side     (side),
    .cur_cell (in_cell),
    .normal   (in_normal),
    .distance (cell_distance),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  fvi_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wdata),
    .pop     (q_pop),
    .rd_data (q_head),
    .stat    (q_stat)
  );

  fvi_back u_back (
    .clk       (clk),
    .rst       (rst),
    .time_step (time_step),
    .head      (q_head),
    .q_empty   (q_stat.empty),
    .q_pop     (q_pop),
    .pop       (pop),
    .out_valid (out_valid),
    .result    (result)
  );

  assign empty                = !out_valid;
  assign face_normal_velocity = result.normal_vel;
  assign face_vel_x           = result.vel[0];
  assign face_vel_y           = result.vel[1];
  assign face_vel_z           = result.vel[2];
  assign face_pressure        = result.pressure;

endmodule
